// ===== sv/gtce_pkg.sv =====
// Shared types and constants for the genotype text checker and encoder.
// No dependencies; the design files other than gtce_fifo refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gtce_pkg;

    localparam int FIELD_W      = 24;   // width of the count fields on the ports
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int COUNT_BITS_D = 24;   // default counter width
    localparam int QUEUE_DEPTH_D = 2;   // default depth of the internal queues

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECESSIVE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_TWO = 2'd2;

    // characters of interest
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE     = 8'h31;
    localparam logic [BYTE_W-1:0] CH_TWO     = 8'h32;

    typedef enum logic [1:0] {
        CLS_NEWLINE,
        CLS_VALUE,
        CLS_SEP,
        CLS_INVALID
    } t_cls;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_INVALID  = 2'd1,
        ERR_MISMATCH = 2'd2,
        ERR_RSVD     = 2'd3
    } t_err;

    // classified byte, front to back
    typedef struct packed {
        t_cls cls;
        logic vbit;
        logic eof;
    } t_item;

    // one result beat
    typedef struct packed {
        logic               value_valid;
        logic               value_bit;
        t_err               error_code;
        logic [FIELD_W-1:0] error_line;
        logic [FIELD_W-1:0] error_column;
        logic [FIELD_W-1:0] lines_total;
        logic               done_res;
    } t_res;

endpackage

`default_nettype wire

// ===== sv/gtce_fifo.sv =====
// Short first-in first-out queue with the head shown combinationally.
// Uses no package; width and depth come from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module gtce_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd, n_rd;
    logic [PW-1:0]    r_wr, n_wr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (push_ok) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gtce_front.sv =====
// Front end: takes raw bytes, classifies them and encodes value bytes.
// Depends on gtce_pkg for character codes, classes and the item type.
`timescale 1ns / 1ps
`default_nettype none

module gtce_front (
    input  wire logic                       i_push,
    input  wire logic [gtce_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                       i_end_of_file,
    input  wire logic                       i_recessive,
    input  wire logic                       i_accept_two,
    input  wire logic                       i_q_full,
    output logic                            o_full,
    output logic                            o_q_push,
    output gtce_pkg::t_item                 o_item
);

    gtce_pkg::t_cls cls;
    logic           vbit;

    always_comb begin
        cls  = gtce_pkg::CLS_INVALID;
        vbit = 1'b0;
        unique case (i_data_byte)
            gtce_pkg::CH_NEWLINE: cls = gtce_pkg::CLS_NEWLINE;
            gtce_pkg::CH_ZERO: cls = gtce_pkg::CLS_VALUE;
            gtce_pkg::CH_ONE: begin
                cls  = gtce_pkg::CLS_VALUE;
                vbit = !i_recessive;
            end
            gtce_pkg::CH_TWO: begin
                // a '2' is only a value when enabled
                cls  = i_accept_two ? gtce_pkg::CLS_VALUE : gtce_pkg::CLS_INVALID;
                vbit = i_accept_two;
            end
            gtce_pkg::CH_SPACE, gtce_pkg::CH_TAB, gtce_pkg::CH_COMMA:
                cls = gtce_pkg::CLS_SEP;
            default: cls = gtce_pkg::CLS_INVALID;
        endcase
    end

    assign o_item.cls  = cls;
    assign o_item.vbit = vbit;
    assign o_item.eof  = i_end_of_file;
    assign o_full      = i_q_full;
    assign o_q_push    = i_push && !i_q_full;

endmodule

`default_nettype wire

// ===== sv/gtce_back.sv =====
// Back end: keeps line, column and value counters, latches the first error
// and builds one result beat per item. Depends on gtce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtce_back #(
    parameter int COUNT_BITS = gtce_pkg::COUNT_BITS_D
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [gtce_pkg::FIELD_W-1:0] i_expected,
    input  wire gtce_pkg::t_item             i_item,
    input  wire logic                        i_item_empty,
    output logic                             o_item_pop,
    input  wire logic                        i_res_full,
    output logic                             o_res_push,
    output gtce_pkg::t_res                   o_res
);

    localparam int EXT_W = COUNT_BITS + gtce_pkg::FIELD_W;
    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] r_line, n_line;
    logic [COUNT_BITS-1:0] r_col,  n_col;
    logic [COUNT_BITS-1:0] r_vil,  n_vil;
    gtce_pkg::t_err        r_err,  n_err;
    logic                  vvalid;
    logic                  vbit;
    logic                  fire;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [gtce_pkg::FIELD_W-1:0] to_field(
        input logic [COUNT_BITS-1:0] v
    );
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[gtce_pkg::FIELD_W-1:0];
    endfunction

    assign fire       = !i_item_empty && !i_res_full;
    assign o_item_pop = fire;
    assign o_res_push = fire;

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        n_vil  = r_vil;
        n_err  = r_err;
        vvalid = 1'b0;
        vbit   = 1'b0;
        if (r_err == gtce_pkg::ERR_NONE) begin
            n_col = sat_inc(r_col);
            case (i_item.cls)
                gtce_pkg::CLS_NEWLINE: begin
                    if (EXT_W'(r_vil) != EXT_W'(i_expected)) begin
                        n_err = gtce_pkg::ERR_MISMATCH;
                    end else begin
                        n_line = sat_inc(r_line);
                        n_vil  = '0;
                        n_col  = '0;
                    end
                end
                gtce_pkg::CLS_VALUE: begin
                    n_vil  = sat_inc(r_vil);
                    vvalid = 1'b1;
                    vbit   = i_item.vbit;
                end
                gtce_pkg::CLS_SEP: ;
                default: n_err = gtce_pkg::ERR_INVALID;
            endcase
        end
    end

    always_comb begin
        o_res.value_valid  = vvalid;
        o_res.value_bit    = vbit;
        o_res.error_code   = n_err;
        o_res.error_line   = to_field(n_line);
        o_res.error_column = to_field(n_col);
        // line counter never drops below one
        o_res.lines_total  = i_item.eof ? to_field(n_line - ONE) : '0;
        o_res.done_res     = i_item.eof || (n_err != gtce_pkg::ERR_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= ONE;
            r_col  <= '0;
            r_vil  <= '0;
            r_err  <= gtce_pkg::ERR_NONE;
        end else if (fire) begin
            if (i_item.eof) begin
                // start afresh for the next file
                r_line <= ONE;
                r_col  <= '0;
                r_vil  <= '0;
                r_err  <= gtce_pkg::ERR_NONE;
            end else begin
                r_line <= n_line;
                r_col  <= n_col;
                r_vil  <= n_vil;
                r_err  <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/genotype_text_checker_encoder_unit.sv =====
// Top level of the genotype text checker and encoder: configuration
// registers, front end, item queue, back end and result queue.
// Depends on gtce_pkg, gtce_front, gtce_fifo and gtce_back.
//
// One text byte goes in per push and exactly one result beat comes out per
// byte, in order. The block takes a byte every cycle while full is low. Its
// item is registered in the item queue and its result in the result queue.
// The sustained rate of one byte per cycle, while nothing stalls, is set by
// the back end, whose counter and error update is combinational. Queues of
// QUEUE_DEPTH beats sit between the front and back ends and on the result
// side, so the producer and consumer may stall independently. The user must
// write configuration only while no byte is in flight; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module genotype_text_checker_encoder_unit #(
    parameter int COUNT_BITS  = gtce_pkg::COUNT_BITS_D,
    parameter int QUEUE_DEPTH = gtce_pkg::QUEUE_DEPTH_D
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gtce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [gtce_pkg::FIELD_W-1:0]   i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [gtce_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_end_of_file,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               o_value_valid,
    output logic                               o_value_bit,
    output logic [1:0]                         o_error_code,
    output logic [gtce_pkg::FIELD_W-1:0]        o_error_line,
    output logic [gtce_pkg::FIELD_W-1:0]        o_error_column,
    output logic [gtce_pkg::FIELD_W-1:0]        o_lines_total,
    output logic                               o_done_res
);

    localparam int ITEM_W = $bits(gtce_pkg::t_item);
    localparam int RES_W  = $bits(gtce_pkg::t_res);

    logic [gtce_pkg::FIELD_W-1:0] r_expected;
    logic                        r_recessive;
    logic                        r_accept_two;

    gtce_pkg::t_item front_item;
    gtce_pkg::t_item back_item;
    gtce_pkg::t_res  back_res;
    gtce_pkg::t_res  out_res;
    logic            iq_push;
    logic            iq_full;
    logic            iq_pop;
    logic            iq_empty;
    logic            rq_push;
    logic            rq_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= '0;
            r_recessive  <= 1'b0;
            r_accept_two <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gtce_pkg::CFG_EXPECTED:   r_expected   <= i_cfg_data;
                gtce_pkg::CFG_RECESSIVE:  r_recessive  <= i_cfg_data[0];
                gtce_pkg::CFG_ACCEPT_TWO: r_accept_two <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    gtce_front u_front (
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_end_of_file(i_end_of_file),
        .i_recessive  (r_recessive),
        .i_accept_two (r_accept_two),
        .i_q_full     (iq_full),
        .o_full       (full),
        .o_q_push     (iq_push),
        .o_item       (front_item)
    );

    gtce_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_item_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (iq_push),
        .i_data (front_item),
        .o_full (iq_full),
        .i_pop  (iq_pop),
        .o_data (back_item),
        .o_empty(iq_empty)
    );

    gtce_back #(
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_expected  (r_expected),
        .i_item      (back_item),
        .i_item_empty(iq_empty),
        .o_item_pop  (iq_pop),
        .i_res_full  (rq_full),
        .o_res_push  (rq_push),
        .o_res       (back_res)
    );

    gtce_fifo #(
        .WIDTH(RES_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (rq_push),
        .i_data (back_res),
        .o_full (rq_full),
        .i_pop  (pop),
        .o_data (out_res),
        .o_empty(empty)
    );

    assign o_value_valid  = out_res.value_valid;
    assign o_value_bit    = out_res.value_bit;
    assign o_error_code   = out_res.error_code;
    assign o_error_line   = out_res.error_line;
    assign o_error_column = out_res.error_column;
    assign o_lines_total  = out_res.lines_total;
    assign o_done_res     = out_res.done_res;

endmodule

`default_nettype wire

// ===== sv/gtce_checker.sv =====
// Port-level checks for the genotype text checker and encoder, attached to
// the top level by the bind below. Depends on gtce_pkg for error codes.
`timescale 1ns / 1ps
`default_nettype none

module gtce_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_full,
    input wire logic       i_empty,
    input wire logic       i_value_valid,
    input wire logic       i_value_bit,
    input wire logic [1:0] i_error_code,
    input wire logic       i_done_res
);

    // queues come out of reset drained
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("queues not drained after reset");

    // an error beat always signals done
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && (i_error_code != gtce_pkg::ERR_NONE) |-> i_done_res)
        else $error("error reported without done");

    // no value is produced once an error is latched
    a_value_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_value_valid |-> i_error_code == gtce_pkg::ERR_NONE)
        else $error("value produced alongside an error");

    a_bit_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_value_valid |-> !i_value_bit)
        else $error("value bit set without a value");

    a_err_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> i_error_code != gtce_pkg::ERR_RSVD)
        else $error("reserved error code shown");

endmodule

bind genotype_text_checker_encoder_unit gtce_checker u_gtce_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_full       (full),
    .i_empty      (empty),
    .i_value_valid(o_value_valid),
    .i_value_bit  (o_value_bit),
    .i_error_code (o_error_code),
    .i_done_res   (o_done_res)
);

`default_nettype wire

// ===== dv/genotype_text_checker_encoder_unit_tb.sv =====
// Self-checking testbench for genotype_text_checker_encoder_unit: streams genotype
// text files through the byte queue and checks every result beat against a
// local model of the checker. Depends on gtce_pkg and the unit itself.
`timescale 1ns / 1ps

module genotype_text_checker_encoder_unit_tb;
    import gtce_pkg::*;

    localparam int HOLD_LEN   = 150;    // long receiver hold-off, in cycles
    localparam int STALL_MAX  = 2000;   // cycles with no beat before giving up
    localparam int SETTLE     = 6;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [FIELD_W-1:0]   i_cfg_data    = '0;
    logic                 push          = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    i_data_byte   = '0;
    logic                 i_end_of_file = 1'b0;
    logic                 empty;
    logic                 pop           = 1'b0;
    logic                 o_value_valid;
    logic                 o_value_bit;
    logic [1:0]           o_error_code;
    logic [FIELD_W-1:0]   o_error_line;
    logic [FIELD_W-1:0]   o_error_column;
    logic [FIELD_W-1:0]   o_lines_total;
    logic                 o_done_res;

    genotype_text_checker_encoder_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_file  (i_end_of_file),
        .empty          (empty),
        .pop            (pop),
        .o_value_valid  (o_value_valid),
        .o_value_bit    (o_value_bit),
        .o_error_code   (o_error_code),
        .o_error_line   (o_error_line),
        .o_error_column (o_error_column),
        .o_lines_total  (o_lines_total),
        .o_done_res     (o_done_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // checker model: registers and running state
    logic [FIELD_W-1:0] cfg_count     = '0;
    logic               cfg_recessive = 1'b0;
    logic               cfg_two       = 1'b0;
    logic [FIELD_W-1:0] line_no       = FIELD_W'(1);
    logic [FIELD_W-1:0] vals_no       = '0;
    logic [FIELD_W-1:0] col_no        = '0;
    t_err               err_state     = ERR_NONE;

    t_res encoded_q[$];
    int   mismatches    = 0;
    int   items_sent    = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_reqs     = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;

    function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_res encode_byte(input logic [BYTE_W-1:0] b, input logic eof);
        t_res r;
        r = '0;
        if (err_state == ERR_NONE) begin
            col_no = bump(col_no);
            if (b == CH_NEWLINE) begin
                if (vals_no != cfg_count) begin
                    err_state = ERR_MISMATCH;
                end else begin
                    line_no = bump(line_no);
                    vals_no = '0;
                    col_no  = '0;
                end
            end else if (b == CH_ZERO || b == CH_ONE || (b == CH_TWO && cfg_two)) begin
                vals_no       = bump(vals_no);
                r.value_valid = 1'b1;
                r.value_bit   = cfg_recessive ? (b == CH_TWO) : (b != CH_ZERO);
            end else if (b == CH_SPACE || b == CH_TAB || b == CH_COMMA) begin
                // separator: nothing moves but the column
            end else begin
                err_state = ERR_INVALID;
            end
        end
        r.error_code   = err_state;
        r.error_line   = line_no;
        r.error_column = col_no;
        r.lines_total  = (eof && line_no != '0) ? line_no - 1'b1 : '0;
        r.done_res     = eof || (err_state != ERR_NONE);
        // end of file starts the next file from scratch, registers kept
        if (eof) begin
            line_no   = FIELD_W'(1);
            vals_no   = '0;
            col_no    = '0;
            err_state = ERR_NONE;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat();
        t_res want;
        if (encoded_q.size() == 0) begin
            $display("%0t result beat with nothing expected", $time);
            mismatches++;
            return;
        end
        want = encoded_q.pop_front();
        check_field("value_valid", FIELD_W'(want.value_valid), FIELD_W'(o_value_valid));
        check_field("value_bit", FIELD_W'(want.value_bit), FIELD_W'(o_value_bit));
        check_field("error_code", FIELD_W'(want.error_code), FIELD_W'(o_error_code));
        check_field("error_line", want.error_line, o_error_line);
        check_field("error_column", want.error_column, o_error_column);
        check_field("lines_total", want.lines_total, o_lines_total);
        check_field("done_res", FIELD_W'(want.done_res), FIELD_W'(o_done_res));
    endtask

    // result side: check accepted beats, then pick the next pop
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_beat();
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("%0t no beat moved for %0d cycles", $time, STALL_MAX);
                $display("[genotype_text_checker_encoder_unit] ERROR");
                $finish;
            end
        end
    end

    // push stays high after a beat so that back-to-back bytes need no toggle
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_data_byte   <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (full);
        encoded_q.push_back(encode_byte(b, eof));
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (encoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [FIELD_W-1:0] count, input logic rec,
                              input logic two);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_EXPECTED;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RECESSIVE;
        i_cfg_data <= FIELD_W'(rec);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ACCEPT_TWO;
        i_cfg_data <= FIELD_W'(two);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_count     = count;
        cfg_recessive = rec;
        cfg_two       = two;
    endtask

    task automatic random_config();
        logic [FIELD_W-1:0] count;
        case ($urandom_range(9))
            0: begin
                count = '1;
            end
            1: begin
                count = FIELD_W'($urandom);
            end
            default: begin
                count = FIELD_W'($urandom_range(5));
            end
        endcase
        set_config(count, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    function automatic logic [BYTE_W-1:0] value_char();
        if (cfg_two && $urandom_range(2) == 0) return CH_TWO;
        return $urandom_range(1) ? CH_ONE : CH_ZERO;
    endfunction

    function automatic logic [BYTE_W-1:0] sep_char();
        case ($urandom_range(2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_COMMA;
        endcase
    endfunction

    // any byte the checker rejects; '2' only counts while it is not a value
    function automatic logic [BYTE_W-1:0] bad_char();
        logic [BYTE_W-1:0] c;
        do begin
            c = BYTE_W'($urandom_range(255));
        end while (c == CH_NEWLINE || c == CH_SPACE || c == CH_TAB || c == CH_COMMA ||
                   c == CH_ZERO || c == CH_ONE || (c == CH_TWO && cfg_two));
        return c;
    endfunction

    // mostly well-formed lines; now and then a short or long line or a bad byte
    task automatic send_genotype_file();
        logic [BYTE_W-1:0] bytes[$];
        int n_lines;
        int nvals;
        int flaw;
        n_lines = $urandom_range(1, 6);
        for (int l = 0; l < n_lines; l++) begin
            nvals = (cfg_count > 8) ? $urandom_range(4) : int'(cfg_count);
            flaw  = $urandom_range(39);
            if (flaw == 0) nvals++;
            else if (flaw == 1 && nvals > 0) nvals--;
            for (int v = 0; v < nvals; v++) begin
                if ($urandom_range(3) == 0) bytes.push_back(sep_char());
                bytes.push_back(value_char());
                if (v + 1 < nvals || $urandom_range(3) == 0) bytes.push_back(sep_char());
            end
            if (flaw == 2) bytes.insert($urandom_range(bytes.size()), bad_char());
            bytes.push_back(CH_NEWLINE);
        end
        // leave the last line open now and then
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) bytes.push_back(value_char());
        end
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send_byte(BYTE_W'($urandom_range(255)), i == n - 1);
    endtask

    task automatic test_directed();
        set_config('0, 1'b0, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        wait_drained();
        set_config(FIELD_W'(2), 1'b0, 1'b1);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_TWO, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        wait_drained();
        // recessive coding, then a line one value too long
        set_config(FIELD_W'(2), 1'b1, 1'b1);
        send_byte(CH_ONE, 1'b0);
        send_byte(CH_TWO, 1'b0);
        send_byte(CH_ONE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();
        set_config('1, 1'b1, 1'b0);
        send_byte(CH_TWO, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(CH_NEWLINE, 1'b1);
        send_byte(CH_ONE, 1'b0);
        send_byte(CH_NEWLINE, 1'b1);
        send_byte(CH_ZERO, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_files(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                wait_drained();
                random_config();
            end
            if ($urandom_range(9) == 0) send_noise();
            else send_genotype_file();
        end
        wait_drained();
    endtask

    // hold the result side off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        int stop_at;
        set_config(FIELD_W'(4), 1'b0, 1'b1);
        hold_reqs++;
        stop_at = items_sent + 60;
        while (items_sent < stop_at) send_genotype_file();
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        send_idle_pct = 18;
        recv_idle_pct = 45;
        test_random_files(500);
        send_idle_pct = 45;
        recv_idle_pct = 18;
        test_random_files(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_files(500);
        wait_drained();
        if (mismatches == 0) begin
            $display("[genotype_text_checker_encoder_unit] OK");
        end else begin
            $display("[genotype_text_checker_encoder_unit] ERROR");
        end
        $finish;
    end

endmodule
